FILE: design/bpcq_pkg.sv
package bpcq_pkg;

	localparam int POSITIONS   = 20;
	localparam int COUNT_WIDTH = 24;
	localparam int POS_W       = $clog2(POSITIONS + 1);
	localparam int TOTAL_W     = COUNT_WIDTH + 2;
	localparam int ROW_W       = 4 * COUNT_WIDTH;
	localparam int RUN_CAP     = (POSITIONS < 31) ? POSITIONS : 31;
	localparam int LOG_STEPS   = 30;

	// 160*log10(2) in Q.26
	localparam logic [31:0] LOG_SCALE = 32'd3232284966;

	// configuration register indexes
	localparam logic [1:0] REG_QUALITY_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_LENGTH_QUALITY    = 2'd1;
	localparam logic [1:0] REG_WARMUP_READS      = 2'd2;

	// base codes
	localparam logic [2:0] BASE_N = 3'd4;

	// input word kinds
	localparam logic KIND_BASE = 1'b0;
	localparam logic KIND_END  = 1'b1;

endpackage

FILE: design/base_profile_consensus_quality.sv
// a counted base (A, C, G, T or N) does a row read then a write back, with busy high
// during the write back; any other base word leaves busy low
// end of read: each column is read from the counter memory and passed through the log2 unit,
// then a summary step runs and the 20 result words follow back to back; a new word
// is taken once the last result has gone out
// results cannot be stalled by the receiver
// reset: every counter reads as one quarter (row valid bits cleared), indexes, run and confirmed count zero
module base_profile_consensus_quality
	import bpcq_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   kind,
	input  logic [2:0]             base_code,
	input  logic [9:0]             start_offset,
	input  logic [15:0]            read_number,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_addr,
	input  logic [15:0]            cfg_wdata,
	output logic                   result_strobe,
	output logic [4:0]             position,
	output logic [1:0]             consensus_base,
	output logic [9:0]             top_quality,
	output logic                   confident,
	output logic [4:0]             bases_counted,
	output logic [4:0]             adapter_length,
	output logic [31:0]            confirmed_reads,
	output logic                   last
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BWR,
		ST_ERD,
		ST_ESUM,
		ST_ENORM,
		ST_ELOG,
		ST_EMUL,
		ST_EQ,
		ST_EFIN,
		ST_EOUT
	} state_t;

	state_t state_q;

	// configuration
	logic [9:0]  quality_threshold_q;
	logic [9:0]  length_quality_q;
	logic [15:0] warmup_reads_q;

	// read tracking
	logic [9:0]       read_index_q;
	logic [POS_W-1:0] column_index_q;
	logic [2:0]       code_q;
	logic [4:0]       adapter_run_q;
	logic [31:0]      confirmed_q;

	// evaluation
	logic [POS_W-1:0]   col_q;
	logic [15:0]        rnum_q;
	logic [POS_W-1:0]   counted_q;
	logic               run_live_q;
	logic [TOTAL_W-1:0] tot_q;
	logic [TOTAL_W-1:0] rest_q;
	logic [1:0]         best_q;
	logic [30:0]        mt_q, mr_q;
	logic [29:0]        ft_q, fr_q;
	logic [4:0]         nt_q, nr_q;
	logic [4:0]         iter_q;
	logic [60:0]        prod_q;
	logic [1:0]         best_arr_q [POSITIONS];
	logic [9:0]         qual_arr_q [POSITIONS];
	logic [POSITIONS-1:0] conf_q;

	// counter memory, one row of four counters per column
	logic [ROW_W-1:0]     mem [POSITIONS];
	logic [ROW_W-1:0]     mem_rdata_q;
	logic [POSITIONS-1:0] row_valid_q;
	logic                 mem_re, mem_we;
	logic [POS_W-1:0]     mem_raddr;
	logic [ROW_W-1:0]     mem_wdata;

	function automatic logic [4:0] msb_idx(input logic [TOTAL_W-1:0] x);
		logic [4:0] n;
		n = '0;
		for (int i = 0; i < TOTAL_W; i++) begin
			if (x[i]) n = 5'(i);
		end
		return n;
	endfunction

	logic accept;
	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);

	// counters of the row just read, absent rows read as the prior
	logic [COUNT_WIDTH-1:0] cnt [4];
	always_comb begin
		for (int b = 0; b < 4; b++) begin
			cnt[b] = row_valid_q[col_q[POS_W-1:0]] ? mem_rdata_q[b*COUNT_WIDTH +: COUNT_WIDTH]
				: COUNT_WIDTH'(1);
		end
	end

	// bumped row for a base word
	logic [ROW_W-1:0] bump_row;
	always_comb begin
		logic [COUNT_WIDTH:0] v;
		for (int b = 0; b < 4; b++) begin
			v = {1'b0, cnt[b]} + (COUNT_WIDTH+1)'(4);
			if ((code_q == BASE_N) || (code_q == 3'(b))) begin
				bump_row[b*COUNT_WIDTH +: COUNT_WIDTH] = v[COUNT_WIDTH] ? '1 : v[COUNT_WIDTH-1:0];
			end else begin
				bump_row[b*COUNT_WIDTH +: COUNT_WIDTH] = cnt[b];
			end
		end
	end

	// column total and argmax, ties to the lowest code
	logic [TOTAL_W-1:0]     sum_tot;
	logic [COUNT_WIDTH-1:0] top_v;
	logic [1:0]             top_k;
	always_comb begin
		sum_tot = '0;
		top_v = cnt[0];
		top_k = 2'd0;
		for (int b = 0; b < 4; b++) begin
			sum_tot = sum_tot + TOTAL_W'(cnt[b]);
		end
		for (int b = 1; b < 4; b++) begin
			if (cnt[b] > top_v) begin
				top_v = cnt[b];
				top_k = 2'(b);
			end
		end
	end

	// normalization of both log operands
	logic [4:0]  nt_c, nr_c;
	assign nt_c = msb_idx(tot_q);
	assign nr_c = msb_idx(rest_q);

	// one squaring step of each log2
	logic [61:0] sq_t, sq_r;
	logic [31:0] st, sr;
	assign sq_t = mt_q * mt_q;
	assign sq_r = mr_q * mr_q;
	assign st = sq_t[61:30];
	assign sr = sq_r[61:30];

	// log difference
	logic [34:0] lt, lr, dlog;
	assign lt = {nt_q, ft_q};
	assign lr = {nr_q, fr_q};
	assign dlog = (lt > lr) ? (lt - lr) : '0;

	logic [10:0] q_raw;
	logic [9:0]  q_sat;
	assign q_raw = prod_q[60:50];
	assign q_sat = q_raw[10] ? 10'd1023 : q_raw[9:0];

	// leading columns covered by the adapter run
	logic all_conf;
	always_comb begin
		all_conf = 1'b1;
		for (int c = 0; c < POSITIONS; c++) begin
			if ((5'(c) < adapter_run_q) && !conf_q[c]) all_conf = 1'b0;
		end
	end

	// memory port control
	always_comb begin
		mem_re = 1'b0;
		mem_raddr = column_index_q;
		if (state_q == ST_IDLE) begin
			mem_re = accept && (kind == KIND_BASE);
		end else if (state_q == ST_ERD) begin
			mem_re = 1'b1;
			mem_raddr = col_q;
		end
		mem_we = (state_q == ST_BWR);
		mem_wdata = bump_row;
	end

	// counter memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[col_q] <= mem_wdata;
		if (mem_re) mem_rdata_q <= mem[mem_raddr];
	end

	// control and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			quality_threshold_q <= 10'd160;
			length_quality_q <= 10'd160;
			warmup_reads_q <= 16'd100;
			read_index_q <= '0;
			column_index_q <= '0;
			code_q <= '0;
			adapter_run_q <= '0;
			confirmed_q <= '0;
			col_q <= '0;
			rnum_q <= '0;
			counted_q <= '0;
			run_live_q <= 1'b0;
			row_valid_q <= '0;
			conf_q <= '0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				case (cfg_addr)
					REG_QUALITY_THRESHOLD: quality_threshold_q <= cfg_wdata[9:0];
					REG_LENGTH_QUALITY:    length_quality_q <= cfg_wdata[9:0];
					REG_WARMUP_READS:      warmup_reads_q <= cfg_wdata;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (kind == KIND_BASE)) begin
						if (read_index_q != 10'd1023) read_index_q <= read_index_q + 10'd1;
						if ((read_index_q >= start_offset) &&
							(column_index_q < POS_W'(POSITIONS))) begin
							if (base_code <= BASE_N) begin
								code_q <= base_code;
								col_q <= column_index_q;
								state_q <= ST_BWR;
							end else begin
								column_index_q <= column_index_q + POS_W'(1);
							end
						end
					end else if (accept && (kind == KIND_END)) begin
						rnum_q <= read_number;
						counted_q <= column_index_q;
						run_live_q <= (read_number == warmup_reads_q);
						read_index_q <= '0;
						column_index_q <= '0;
						col_q <= '0;
						state_q <= ST_ERD;
					end
				end
				ST_BWR: begin
					row_valid_q[col_q] <= 1'b1;
					column_index_q <= column_index_q + POS_W'(1);
					state_q <= ST_IDLE;
				end
				ST_ERD: begin
					state_q <= ST_ESUM;
				end
				ST_ESUM: begin
					tot_q <= sum_tot;
					rest_q <= sum_tot - TOTAL_W'(top_v);
					best_q <= top_k;
					state_q <= ST_ENORM;
				end
				ST_ENORM: begin
					nt_q <= nt_c;
					nr_q <= nr_c;
					mt_q <= 31'(tot_q) << (5'd30 - nt_c);
					mr_q <= 31'(rest_q) << (5'd30 - nr_c);
					ft_q <= '0;
					fr_q <= '0;
					iter_q <= '0;
					state_q <= ST_ELOG;
				end
				ST_ELOG: begin
					mt_q <= st[31] ? st[31:1] : st[30:0];
					mr_q <= sr[31] ? sr[31:1] : sr[30:0];
					ft_q <= {ft_q[28:0], st[31]};
					fr_q <= {fr_q[28:0], sr[31]};
					iter_q <= iter_q + 5'd1;
					if (iter_q == 5'(LOG_STEPS - 1)) state_q <= ST_EMUL;
				end
				ST_EMUL: begin
					prod_q <= dlog[34:6] * LOG_SCALE;
					state_q <= ST_EQ;
				end
				ST_EQ: begin
					qual_arr_q[col_q] <= q_sat;
					best_arr_q[col_q] <= best_q;
					conf_q[col_q] <= (q_sat >= quality_threshold_q);
					// leading run of strong columns
					if (run_live_q) begin
						if (q_sat >= length_quality_q) begin
							if (adapter_run_q < 5'(RUN_CAP)) adapter_run_q <= adapter_run_q + 5'd1;
						end else begin
							run_live_q <= 1'b0;
						end
					end
					if (col_q == POS_W'(POSITIONS - 1)) begin
						state_q <= ST_EFIN;
					end else begin
						col_q <= col_q + POS_W'(1);
						state_q <= ST_ERD;
					end
				end
				ST_EFIN: begin
					if ((rnum_q >= warmup_reads_q) && all_conf && (confirmed_q != '1)) begin
						confirmed_q <= confirmed_q + 32'd1;
					end
					col_q <= '0;
					state_q <= ST_EOUT;
				end
				ST_EOUT: begin
					if (col_q == POS_W'(POSITIONS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						col_q <= col_q + POS_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result word
	assign result_strobe  = (state_q == ST_EOUT);
	assign position       = 5'(col_q);
	assign consensus_base = best_arr_q[col_q];
	assign top_quality    = qual_arr_q[col_q];
	assign confident      = conf_q[col_q];
	assign bases_counted  = 5'(counted_q);
	assign adapter_length = adapter_run_q;
	assign confirmed_reads = confirmed_q;
	assign last           = result_strobe && (col_q == POS_W'(POSITIONS - 1));

	// checks
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy) else $error("result word while not busy");
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |=> result_strobe) else $error("result burst broken");
	a_first_pos: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_strobe) |-> position == 5'd0) else $error("burst not at column zero");
	a_last_free: assert property (@(posedge clk) disable iff (!arst_n)
		last |=> !busy) else $error("busy after last result");

endmodule
